[design/ps2mct_pkg.sv]
`default_nettype none

package ps2mct_pkg;

    localparam int POSITION_BITS_DEF = 12;
    localparam int OUT_POS_BITS      = 12;
    localparam int SIZE_BITS         = 13;
    localparam int BYTE_BITS         = 8;
    localparam int APB_ADDR_BITS     = 4;
    localparam int APB_DATA_BITS     = 32;
    localparam int M_TDATA_BITS      = 32;

    localparam int SYNC_BIT_IDX  = 3;
    localparam int LEFT_BIT_IDX  = 0;
    localparam int RIGHT_BIT_IDX = 1;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(320);
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(200);

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                 enable;
        logic [SIZE_BITS-1:0] screen_width;
        logic [SIZE_BITS-1:0] screen_height;
    } cfg_t;

endpackage

`default_nettype wire

[design/ps2mct_apb_regs.sv]
`default_nettype none

module ps2mct_apb_regs
    import ps2mct_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output cfg_t                          cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_ENABLE: cfg_next.enable        = pwdata[0];
                REG_WIDTH:  cfg_next.screen_width  = pwdata[SIZE_BITS-1:0];
                REG_HEIGHT: cfg_next.screen_height = pwdata[SIZE_BITS-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENABLE: prdata = APB_DATA_BITS'(cfg_reg.enable);
            REG_WIDTH:  prdata = APB_DATA_BITS'(cfg_reg.screen_width);
            REG_HEIGHT: prdata = APB_DATA_BITS'(cfg_reg.screen_height);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.screen_width  <= WIDTH_RESET;
            cfg_reg.screen_height <= HEIGHT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[design/ps2mct_axis_clamp.sv]
`default_nettype none

module ps2mct_axis_clamp
    import ps2mct_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic        [POSITION_BITS-1:0] pos,
    input  wire logic signed [BYTE_BITS:0]       delta,
    input  wire logic        [SIZE_BITS-1:0]     size,
    output logic             [POSITION_BITS-1:0] pos_next
);

    localparam int SW = (POSITION_BITS + 1 > SIZE_BITS) ? POSITION_BITS + 1 : SIZE_BITS;
    localparam int CW = SW + 2;

    logic signed [CW-1:0] pos_s;
    logic signed [CW-1:0] delta_s;
    logic signed [CW-1:0] size_s;
    logic signed [CW-1:0] cap_s;
    logic signed [CW-1:0] lim_s;
    logic signed [CW-1:0] sum_s;
    logic signed [CW-1:0] res_s;

    always_comb begin
        pos_s   = CW'(pos);
        delta_s = CW'(delta);
        size_s  = CW'(size);
        cap_s   = CW'(1) << POSITION_BITS;
        if (size == '0) begin
            lim_s = CW'(1);
        end else if (size_s > cap_s) begin
            lim_s = cap_s;
        end else begin
            lim_s = size_s;
        end
        sum_s = pos_s + delta_s;
        if (sum_s < 0) begin
            res_s = '0;
        end else if (sum_s >= lim_s) begin
            res_s = lim_s - CW'(1);
        end else begin
            res_s = sum_s;
        end
        pos_next = res_s[POSITION_BITS-1:0];
    end

endmodule

`default_nettype wire

[design/ps2mct_packet_core.sv]
`default_nettype none

module ps2mct_packet_core
    import ps2mct_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire cfg_t                    cfg,
    input  wire logic                    byte_valid,
    input  wire logic [BYTE_BITS-1:0]    byte_data,
    output logic                         proc_ready,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic      [OUT_POS_BITS-1:0] cursor_x,
    output logic      [OUT_POS_BITS-1:0] cursor_y,
    output logic                         left_button,
    output logic                         right_button
);

    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [BYTE_BITS-1:0]      status_reg, status_next;
    logic [BYTE_BITS-1:0]      dx_reg, dx_next;
    logic [POSITION_BITS-1:0]  pos_x_reg, pos_x_next;
    logic [POSITION_BITS-1:0]  pos_y_reg, pos_y_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [OUT_POS_BITS-1:0]   cursor_x_reg, cursor_x_next;
    logic [OUT_POS_BITS-1:0]   cursor_y_reg, cursor_y_next;
    logic                      left_reg, left_next;
    logic                      right_reg, right_next;

    logic                      fire;
    logic signed [BYTE_BITS:0] dx_delta;
    logic signed [BYTE_BITS:0] dy_delta;
    logic [POSITION_BITS-1:0]  clamp_x;
    logic [POSITION_BITS-1:0]  clamp_y;
    logic [OUT_POS_BITS+POSITION_BITS-1:0] x_wide;
    logic [OUT_POS_BITS+POSITION_BITS-1:0] y_wide;

    assign proc_ready = !m_tvalid_reg || m_tready;
    assign fire       = byte_valid && proc_ready;

    assign dx_delta = $signed({dx_reg[BYTE_BITS-1], dx_reg});
    assign dy_delta = -$signed({byte_data[BYTE_BITS-1], byte_data});

    ps2mct_axis_clamp #(.POSITION_BITS(POSITION_BITS)) u_clamp_x (
        .pos      (pos_x_reg),
        .delta    (dx_delta),
        .size     (cfg.screen_width),
        .pos_next (clamp_x)
    );

    ps2mct_axis_clamp #(.POSITION_BITS(POSITION_BITS)) u_clamp_y (
        .pos      (pos_y_reg),
        .delta    (dy_delta),
        .size     (cfg.screen_height),
        .pos_next (clamp_y)
    );

    assign x_wide = {{OUT_POS_BITS{1'b0}}, clamp_x};
    assign y_wide = {{OUT_POS_BITS{1'b0}}, clamp_y};

    always_comb begin
        phase_next    = phase_reg;
        status_next   = status_reg;
        dx_next       = dx_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        if (fire && cfg.enable) begin
            unique case (phase_reg)
                PH_STATUS: begin
                    if (byte_data[SYNC_BIT_IDX]) begin
                        status_next = byte_data;
                        phase_next  = PH_DX;
                    end
                end
                PH_DX: begin
                    dx_next    = byte_data;
                    phase_next = PH_DY;
                end
                PH_DY: begin
                    phase_next    = PH_STATUS;
                    pos_x_next    = clamp_x;
                    pos_y_next    = clamp_y;
                    m_tvalid_next = 1'b1;
                    cursor_x_next = x_wide[OUT_POS_BITS-1:0];
                    cursor_y_next = y_wide[OUT_POS_BITS-1:0];
                    left_next     = status_reg[LEFT_BIT_IDX];
                    right_next    = status_reg[RIGHT_BIT_IDX];
                end
                default: phase_next = PH_STATUS;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_STATUS;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        status_reg   <= status_next;
        dx_reg       <= dx_next;
        cursor_x_reg <= cursor_x_next;
        cursor_y_reg <= cursor_y_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
    end

    assign m_tvalid     = m_tvalid_reg;
    assign cursor_x     = cursor_x_reg;
    assign cursor_y     = cursor_y_reg;
    assign left_button  = left_reg;
    assign right_button = right_reg;

`ifndef SYNTHESIS
    a_result_from_dy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(phase_reg == PH_DY))
        else $error("result raised outside the last byte of a packet");

    a_phase_holds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire && cfg.enable) |=> $stable(phase_reg))
        else $error("packet phase moved without a processed byte");

    a_dy_completes: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && cfg.enable && phase_reg == PH_DY) |=> (phase_reg == PH_STATUS && m_tvalid_reg))
        else $error("completed packet did not produce a result");

    a_disabled_keeps_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !cfg.enable) |=> ($stable(pos_x_reg) && $stable(pos_y_reg)))
        else $error("position changed while disabled");
`endif

endmodule

`default_nettype wire

[design/ps2_mouse_packet_cursor_tracker_core.sv]
// PS/2 mouse cursor tracker. Raw mouse bytes enter on the s_ stream, one per
// transaction; three-byte packets are assembled (a packet start byte without
// bit 3 set is dropped), and each completed packet yields one m_ transaction
// with the clamped cursor position and the left/right button bits. Throughput
// is one byte per clock unless a result waits on m_tready: a byte is
// registered on input, then updates the packet state and position through a
// single add-and-clamp stage into the result register. s_tready follows
// m_tready combinationally through the result register's free slot. Registers
// (APB, 32-bit): 0x0 enable, 0x4 screen_width, 0x8 screen_height; change them
// only while the stream is idle.
`default_nettype none

module ps2_mouse_packet_cursor_tracker_core
    import ps2mct_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [BYTE_BITS-1:0]     s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [M_TDATA_BITS-1:0]  m_tdata,   // [11:0] cursor_x, [23:12] cursor_y,
                                                     // [24] left_button, [25] right_button
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    cfg_t                    cfg;
    logic                    in_valid_reg, in_valid_next;
    logic [BYTE_BITS-1:0]    in_byte_reg, in_byte_next;
    logic                    proc_ready;
    logic                    s_fire;
    logic [OUT_POS_BITS-1:0] cursor_x;
    logic [OUT_POS_BITS-1:0] cursor_y;
    logic                    left_button;
    logic                    right_button;

    ps2mct_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = !in_valid_reg || proc_ready;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = s_fire || (in_valid_reg && !proc_ready);
        in_byte_next  = s_fire ? s_tdata : in_byte_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_byte_reg <= in_byte_next;
    end

    ps2mct_packet_core #(.POSITION_BITS(POSITION_BITS)) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .byte_valid   (in_valid_reg),
        .byte_data    (in_byte_reg),
        .proc_ready   (proc_ready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .left_button  (left_button),
        .right_button (right_button)
    );

    assign m_tdata = {{(M_TDATA_BITS - 2*OUT_POS_BITS - 2){1'b0}},
                      right_button, left_button, cursor_y, cursor_x};

endmodule

`default_nettype wire
